// ===== hw/rtl/bsc_pkg.sv =====
// Package for the barometric compensation pipeline: item types, coefficient
// bundle, constants and the split 64-bit multiply helpers. No dependencies.
package bsc_pkg;

  // One raw reading pair.
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } bsc_in_t;

  // One compensated result.
  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
  } bsc_out_t;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    REG_TEMP_COEFFS = 8'd0,
    REG_PRESS_A     = 8'd1,
    REG_PRESS_B     = 8'd2,
    REG_PRESS_NINE  = 8'd3
  } bsc_reg_e;

  // Calibration words as held by the configuration registers.
  typedef struct packed {
    logic [47:0] tc;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] p9;
  } bsc_coef_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [31:0] temp;
  } bsc_side_t;

  // Divider request: magnitudes plus side data.
  typedef struct packed {
    logic [63:0] num_abs;
    logic [63:0] den_abs;
    bsc_side_t   side;
  } bsc_div_req_t;

  // Divider response: unsigned quotient plus side data.
  typedef struct packed {
    logic [63:0] quo;
    bsc_side_t   side;
  } bsc_div_rsp_t;

  localparam int unsigned DivSteps = 64;

  localparam logic signed [32:0] TfineOffset = 33'sd128000;
  localparam logic [20:0]        PressOffset = 21'd1048576;
  localparam logic signed [16:0] PressScale  = 17'sd3125;
  localparam logic [63:0]        PressSeed   = 64'h0000_8000_0000_0000;
  localparam logic [31:0]        TempRound   = 32'd128;

  // Sign-extend a 16-bit coefficient to 17 bits.
  function automatic logic signed [16:0] sx17(input logic [15:0] v);
    return $signed({v[15], v});
  endfunction

  // Low half of x times c: full product of x[31:0] (unsigned) and c.
  function automatic logic [49:0] mul_lo(input logic [63:0] x,
                                         input logic signed [16:0] c);
    logic signed [49:0] xa;
    logic signed [49:0] ca;
    logic signed [49:0] pr;
    xa = $signed({18'b0, x[31:0]});
    ca = 50'(c);
    pr = xa * ca;
    return pr;
  endfunction

  // High half of x times c, only the bits that land below bit 64.
  function automatic logic [31:0] mul_hi(input logic [63:0] x,
                                         input logic signed [16:0] c);
    logic [31:0] ce;
    ce = 32'(c);
    return x[63:32] * ce;
  endfunction

  // Join the two partial products into the wrapped 64-bit product.
  function automatic logic [63:0] mul_join(input logic [49:0] lo,
                                           input logic [31:0] hi);
    return {{14{lo[49]}}, lo} + {hi, 32'b0};
  endfunction

endpackage

// ===== hw/rtl/bsc_front.sv =====
// Front stages: temperature path and pressure numerator and divisor.
// Depends on bsc_pkg. Nine register stages, global advance enable.
module bsc_front import bsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  bsc_in_t      item_i,
  input  bsc_coef_t    coef_i,
  output logic         valid_o,
  output bsc_div_req_t req_o
);

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic signed [15:0] p2, p5;
  logic [8:0]         v_q;

  assign t1 = coef_i.tc[15:0];
  assign t2 = $signed(coef_i.tc[31:16]);
  assign t3 = $signed(coef_i.tc[47:32]);
  assign p2 = $signed(coef_i.pa[31:16]);
  assign p5 = $signed(coef_i.pb[15:0]);

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:0], valid_i};
    end
  end
  assign valid_o = v_q[8];

  // Stage 1: the two temperature products.
  logic signed [17:0] x1;
  logic signed [16:0] dd;
  logic signed [33:0] pa_full, dsq_full;
  logic [31:0]        pa1_q, dsq1_q;
  logic [19:0]        rp1_q;

  assign x1 = $signed({1'b0, item_i.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dd = $signed({1'b0, item_i.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign pa_full  = x1 * t2;
  assign dsq_full = dd * dd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa1_q  <= pa_full[31:0];
      dsq1_q <= dsq_full[31:0];
      rp1_q  <= item_i.raw_pressure;
    end
  end

  // Stage 2: scale, then the cubic temperature term.
  logic signed [31:0] b1;
  logic signed [47:0] bp_full;
  logic [31:0]        a2_q, bp2_q;
  logic [19:0]        rp2_q;

  assign b1      = $signed(dsq1_q) >>> 12;
  assign bp_full = b1 * t3;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= 32'($signed(pa1_q) >>> 11);
      bp2_q <= bp_full[31:0];
      rp2_q <= rp1_q;
    end
  end

  // Stage 3: fine temperature.
  logic [31:0] tf3_q;
  logic [19:0] rp3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tf3_q <= a2_q + 32'($signed(bp2_q) >>> 14);
      rp3_q <= rp2_q;
    end
  end

  // Stage 4: temperature output and first pressure products.
  logic [31:0]        t5;
  logic signed [32:0] v1;
  logic signed [65:0] sq_full;
  logic signed [48:0] v5_full, v2_full;
  logic [31:0]        temp4_q;
  logic [63:0]        sq4_q;
  logic [48:0]        v5_4_q, v2_4_q;
  logic [19:0]        rp4_q;

  assign t5      = {tf3_q[29:0], 2'b00} + tf3_q + TempRound;
  assign v1      = $signed({tf3_q[31], tf3_q}) - TfineOffset;
  assign sq_full = v1 * v1;
  assign v5_full = v1 * p5;
  assign v2_full = v1 * p2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      temp4_q <= 32'($signed(t5) >>> 8);
      sq4_q   <= sq_full[63:0];
      v5_4_q  <= v5_full;
      v2_4_q  <= v2_full;
      rp4_q   <= rp3_q;
    end
  end

  // Stage 5: partial products of the square with P6 and P3.
  logic [49:0] s6lo5_q, s3lo5_q;
  logic [31:0] s6hi5_q, s3hi5_q;
  logic [31:0] temp5_q;
  logic [48:0] v5_5_q, v2_5_q;
  logic [19:0] rp5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6lo5_q <= mul_lo(sq4_q, sx17(coef_i.pb[31:16]));
      s6hi5_q <= mul_hi(sq4_q, sx17(coef_i.pb[31:16]));
      s3lo5_q <= mul_lo(sq4_q, sx17(coef_i.pa[47:32]));
      s3hi5_q <= mul_hi(sq4_q, sx17(coef_i.pa[47:32]));
      temp5_q <= temp4_q;
      v5_5_q  <= v5_4_q;
      v2_5_q  <= v2_4_q;
      rp5_q   <= rp4_q;
    end
  end

  // Stage 6: offset term and the divisor before P1.
  logic [63:0] v2_sum, v1_sum, p3_term;
  logic [63:0] v2_6_q, v1b6_q;
  logic [31:0] temp6_q;
  logic [19:0] rp6_q;

  assign v2_sum  = mul_join(s6lo5_q, s6hi5_q) + ({{15{v5_5_q[48]}}, v5_5_q} << 17)
                 + ({{48{coef_i.pa[63]}}, coef_i.pa[63:48]} << 35);
  assign p3_term = 64'($signed(mul_join(s3lo5_q, s3hi5_q)) >>> 8);
  assign v1_sum  = p3_term + ({{15{v2_5_q[48]}}, v2_5_q} << 12) + PressSeed;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v2_6_q  <= v2_sum;
      v1b6_q  <= v1_sum;
      temp6_q <= temp5_q;
      rp6_q   <= rp5_q;
    end
  end

  // Stage 7: dividend before scaling, partial products for both scalings.
  logic [20:0] pr;
  logic [63:0] pdiff;
  logic [49:0] nlo7_q, dlo7_q;
  logic [31:0] nhi7_q, dhi7_q;
  logic [31:0] temp7_q;

  assign pr    = PressOffset - {1'b0, rp6_q};
  assign pdiff = ({43'b0, pr} << 31) - v2_6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nlo7_q  <= mul_lo(pdiff, PressScale);
      nhi7_q  <= mul_hi(pdiff, PressScale);
      dlo7_q  <= mul_lo(v1b6_q, $signed({1'b0, coef_i.pa[15:0]}));
      dhi7_q  <= mul_hi(v1b6_q, $signed({1'b0, coef_i.pa[15:0]}));
      temp7_q <= temp6_q;
    end
  end

  // Stage 8: dividend and divisor.
  logic [63:0] num8_q, den8_q;
  logic [31:0] temp8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num8_q  <= mul_join(nlo7_q, nhi7_q);
      den8_q  <= 64'($signed(mul_join(dlo7_q, dhi7_q)) >>> 33);
      temp8_q <= temp7_q;
    end
  end

  // Stage 9: magnitudes and quotient sign for the divider.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_o.num_abs   <= num8_q[63] ? 64'd0 - num8_q : num8_q;
      req_o.den_abs   <= den8_q[63] ? 64'd0 - den8_q : den8_q;
      req_o.side.neg  <= num8_q[63] ^ den8_q[63];
      req_o.side.zero <= (den8_q == 64'd0);
      req_o.side.temp <= temp8_q;
    end
  end

endmodule

// ===== hw/rtl/bsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Depends on bsc_pkg. Side data travels with each item.
module bsc_div import bsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  bsc_div_req_t req_i,
  output logic         valid_o,
  output bsc_div_rsp_t rsp_o
);

  logic [63:0] r_q    [DivSteps];
  logic [63:0] nq_q   [DivSteps];
  logic [63:0] d_q    [DivSteps];
  bsc_side_t   side_q [DivSteps];
  logic        v_q    [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [63:0] r_in, nq_in, d_in, r_sh;
    logic [64:0] trial;
    bsc_side_t   side_in;
    logic        v_in;

    if (i == 0) begin : g_first
      assign r_in    = '0;
      assign nq_in   = req_i.num_abs;
      assign d_in    = req_i.den_abs;
      assign side_in = req_i.side;
      assign v_in    = valid_i;
    end else begin : g_next
      assign r_in    = r_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign d_in    = d_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    // Shift in the next dividend bit and try a subtract.
    assign r_sh  = {r_in[62:0], nq_in[63]};
    assign trial = {1'b0, r_sh} - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]    <= trial[64] ? r_sh : trial[63:0];
        nq_q[i]   <= {nq_in[62:0], ~trial[64]};
        d_q[i]    <= d_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o    = v_q[DivSteps-1];
  assign rsp_o.quo  = nq_q[DivSteps-1];
  assign rsp_o.side = side_q[DivSteps-1];

endmodule

// ===== hw/rtl/bsc_back.sv =====
// Back stages: signed quotient, P7..P9 correction and output register.
// Depends on bsc_pkg. Six register stages, the last one drives the port.
module bsc_back import bsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  bsc_div_rsp_t rsp_i,
  input  bsc_coef_t    coef_i,
  output logic         valid_o,
  output bsc_out_t     item_o
);

  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end
  assign valid_o = v_q[5];

  // Stage 1: apply the quotient sign.
  logic [63:0] p1_q;
  bsc_side_t   sd1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= rsp_i.side.neg ? 64'd0 - rsp_i.quo : rsp_i.quo;
      sd1_q <= rsp_i.side;
    end
  end

  // Stage 2: square of the scaled pressure in halves, P8 partials.
  logic [63:0] ph, ll;
  logic [31:0] lh;
  logic [63:0] ll2_q, p2_q;
  logic [31:0] lh2_q, w2hi2_q;
  logic [49:0] w2lo2_q;
  bsc_side_t   sd2_q;

  assign ph = 64'($signed(p1_q) >>> 13);
  assign ll = ph[31:0] * ph[31:0];
  assign lh = ph[31:0] * ph[63:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll2_q   <= ll;
      lh2_q   <= lh;
      w2lo2_q <= mul_lo(p1_q, sx17(coef_i.pb[63:48]));
      w2hi2_q <= mul_hi(p1_q, sx17(coef_i.pb[63:48]));
      p2_q    <= p1_q;
      sd2_q   <= sd1_q;
    end
  end

  // Stage 3: join the square and the P8 term.
  logic [63:0] sq3_q, w2_3_q, p3_q;
  bsc_side_t   sd3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq3_q  <= ll2_q + {lh2_q[30:0], 1'b0, 32'b0};
      w2_3_q <= 64'($signed(mul_join(w2lo2_q, w2hi2_q)) >>> 19);
      p3_q   <= p2_q;
      sd3_q  <= sd2_q;
    end
  end

  // Stage 4: P9 partials.
  logic [49:0] w1lo4_q;
  logic [31:0] w1hi4_q;
  logic [63:0] w2_4_q, p4_q;
  bsc_side_t   sd4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1lo4_q <= mul_lo(sq3_q, sx17(coef_i.p9));
      w1hi4_q <= mul_hi(sq3_q, sx17(coef_i.p9));
      w2_4_q  <= w2_3_q;
      p4_q    <= p3_q;
      sd4_q   <= sd3_q;
    end
  end

  // Stage 5: sum of the pressure and both corrections.
  logic [63:0] w1;
  logic [63:0] sum5_q;
  bsc_side_t   sd5_q;

  assign w1 = 64'($signed(mul_join(w1lo4_q, w1hi4_q)) >>> 25);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum5_q <= p4_q + w1 + w2_4_q;
      sd5_q  <= sd4_q;
    end
  end

  // Stage 6: final scaling and P7 offset, zero when the divisor was zero.
  logic [63:0] scaled;
  logic [31:0] pres;

  assign scaled = 64'($signed(sum5_q) >>> 8);
  assign pres   = scaled[31:0] + {{12{coef_i.pb[47]}}, coef_i.pb[47:32], 4'b0000};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o.temperature_centi <= $signed(sd5_q.temp);
      item_o.pressure_q24_8    <= sd5_q.zero ? 32'd0 : pres;
    end
  end

endmodule

// ===== hw/rtl/baro_sensor_compensation_top.sv =====
// Top level of the barometric compensation pipeline: configuration
// registers, stall control and the front, divider and back stages.
// Depends on bsc_pkg, bsc_front, bsc_div and bsc_back.
//
// The block takes one raw pressure and temperature pair per clock cycle when
// not stalled and returns one compensated result for each, in order, after
// nine front stages for the temperature, numerator and divisor, 64 divider
// stages that resolve one quotient bit each, and six back stages for the
// pressure corrections and the output register. The whole pipeline advances
// together; it holds only while a result waits at the output under stall.
// Calibration registers are written with no wait state and must only change
// while the pipeline is empty.
module baro_sensor_compensation_top import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bsc_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bsc_out_t    out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  bsc_coef_t    coef_q;
  logic         en;
  logic         f_valid, d_valid;
  bsc_div_req_t f_req;
  bsc_div_rsp_t d_rsp;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEMP_COEFFS: coef_q.tc <= cfg_data_i[47:0];
        REG_PRESS_A:     coef_q.pa <= cfg_data_i;
        REG_PRESS_B:     coef_q.pb <= cfg_data_i;
        REG_PRESS_NINE:  coef_q.p9 <= cfg_data_i[15:0];
        default:         coef_q    <= coef_q;
      endcase
    end
  end

  // The pipeline moves unless a finished item is held at the output.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  bsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .coef_i  (coef_q),
    .valid_o (f_valid),
    .req_o   (f_req)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .req_i   (f_req),
    .valid_o (d_valid),
    .rsp_o   (d_rsp)
  );

  bsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .rsp_i   (d_rsp),
    .coef_i  (coef_q),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  // The input is held back only by a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A new result appears only after the pipeline advanced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("result appeared while the pipeline was held");

  // A held result stays in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("held result changed under stall");

endmodule
